@@ hdl/buddy_block_allocator_defines.svh @@
// assertion macros for the buddy block allocator
// depends on clk and arst_n being visible where the macros are used
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BBA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("buddy allocator check failed");

// next-cycle implication, checked out of reset
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("buddy allocator check failed");

`endif

@@ hdl/bba_pkg.sv @@
// shared constants for the buddy block allocator
// no dependencies
`timescale 1ns / 1ps

package bba_pkg;

	// payload widths
	localparam int KIND_W   = 1;
	localparam int BYTES_W  = 15;
	localparam int OFFS_W   = 14;
	localparam int STATUS_W = 2;
	localparam int TOP_W    = 4;

	// parameter defaults
	localparam int MIN_BLOCK_DEF = 32;
	localparam int LEVELS_DEF    = 10;
	localparam int TOP_RESET     = 5;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
	localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TOO_BIG = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd2;

endpackage

@@ hdl/bba_ifs.sv @@
// valid/ready channel interfaces for request, result and config
// depends on bba_pkg
`timescale 1ns / 1ps

interface bba_req_if;
	logic                         valid;
	logic                         ready;
	logic [bba_pkg::KIND_W-1:0]   kind;
	logic [bba_pkg::BYTES_W-1:0]  req_bytes;
	logic [bba_pkg::OFFS_W-1:0]   block_offset;
	modport source (output valid, kind, req_bytes, block_offset, input ready);
	modport sink (input valid, kind, req_bytes, block_offset, output ready);
endinterface

interface bba_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bba_pkg::OFFS_W-1:0]    grant_offset;
	logic [bba_pkg::STATUS_W-1:0]  status;
	modport source (output valid, grant_offset, status, input ready);
	modport sink (input valid, grant_offset, status, output ready);
endinterface

interface bba_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [bba_pkg::TOP_W-1:0]  top_level;
	modport source (output valid, top_level, input ready);
	modport sink (input valid, top_level, output ready);
endinterface

@@ hdl/buddy_block_allocator.sv @@
// buddy allocator top level: sequencer, node address unit and result register
// depends on bba_pkg, bba_ifs, bba_node_mem, bba_div, buddy_block_allocator_defines.svh
`timescale 1ns / 1ps

// Buddy allocator over a region of MIN_BLOCK << top_level bytes, one free bit
// per tree node held in a single-port-write, registered-read memory. One
// request is handled at a time; the block is not ready while it works. An
// allocate request scans the tree node by node, each node probed through an
// address state and a check state, from the lowest-addressed block of the
// requested level upward. A free request waits for the offset divide (a
// reciprocal multiply), then passes the set, read, check and two merge states
// for each merged level. An oversized request goes straight to the done
// state. After reset and after every top_level write the free map is cleared
// by a pass over all (1 << LEVELS) - 1 nodes, one node per cycle, during
// which no request is accepted; a top_level write also gives back every
// block. The result sits in an output register.

`include "buddy_block_allocator_defines.svh"

module buddy_block_allocator #(
	parameter int MIN_BLOCK = bba_pkg::MIN_BLOCK_DEF,
	parameter int LEVELS    = bba_pkg::LEVELS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	bba_req_if.sink  req,
	bba_rsp_if.source rsp,
	bba_cfg_if.sink  cfg
);

	localparam int NODES = (1 << LEVELS) - 1;
	localparam int AW    = LEVELS;
	localparam int BW    = LEVELS;
	localparam int LW    = $clog2(LEVELS + 1);
	localparam int GW    = BW + $clog2(MIN_BLOCK + 1);
	localparam int TOP_INIT = (bba_pkg::TOP_RESET < LEVELS) ? bba_pkg::TOP_RESET : LEVELS - 1;

	// sequencer codes
	localparam int SW = 4;
	localparam logic [SW-1:0] ST_IDLE  = 4'd0;
	localparam logic [SW-1:0] ST_CLEAR = 4'd1;
	localparam logic [SW-1:0] ST_ARD   = 4'd2;
	localparam logic [SW-1:0] ST_ACHK  = 4'd3;
	localparam logic [SW-1:0] ST_ATAKE = 4'd4;
	localparam logic [SW-1:0] ST_ASPL  = 4'd5;
	localparam logic [SW-1:0] ST_FDIV  = 4'd6;
	localparam logic [SW-1:0] ST_FSET  = 4'd7;
	localparam logic [SW-1:0] ST_FRD   = 4'd8;
	localparam logic [SW-1:0] ST_FCHK  = 4'd9;
	localparam logic [SW-1:0] ST_FMA   = 4'd10;
	localparam logic [SW-1:0] ST_FMB   = 4'd11;
	localparam logic [SW-1:0] ST_DONE  = 4'd12;

	logic [SW-1:0] state_q;
	logic [LW-1:0] top_q;
	logic [LW-1:0] lvl_q;
	logic [LW-1:0] l_q;
	logic [BW-1:0] b_q;
	logic [AW-1:0] clr_q;
	logic [bba_pkg::OFFS_W-1:0]   res_grant_q;
	logic [bba_pkg::STATUS_W-1:0] res_status_q;
	logic                         out_valid_q;
	logic [bba_pkg::OFFS_W-1:0]   out_grant_q;
	logic [bba_pkg::STATUS_W-1:0] out_status_q;

	logic [LW-1:0] size_lvl;
	logic [BW-1:0] b_sel;
	logic [AW-1:0] node_addr;
	logic [AW-1:0] top_addr;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic          mem_wdata;
	logic          mem_rdata;
	logic          div_start;
	logic          div_done;
	logic [bba_pkg::OFFS_W-1:0] div_quo;
	logic [bba_pkg::OFFS_W-1:0] blk;
	logic [BW-1:0] b_next;
	logic [BW-1:0] lvl_count;
	logic [GW-1:0] grant_full;
	logic          req_fire;
	logic          out_free;

	// level whose block holds the request size
	always_comb begin
		size_lvl = LW'(LEVELS);
		for (int l = LEVELS - 1; l >= 0; l--) begin
			if (32'(req.req_bytes) <= (32'(MIN_BLOCK) << l)) begin
				size_lvl = LW'(l);
			end
		end
	end

	// shared node address unit
	always_comb begin
		case (state_q)
			ST_ASPL:        b_sel = b_q | BW'(1);
			ST_FRD, ST_FMB: b_sel = b_q ^ BW'(1);
			default:        b_sel = b_q;
		endcase
	end
	assign node_addr = ((AW'(1) << (LW'(LEVELS - 1) - l_q)) - AW'(1)) + AW'(b_sel);
	assign top_addr  = (AW'(1) << (LW'(LEVELS - 1) - top_q)) - AW'(1);

	// scan bookkeeping and grant offset
	assign b_next     = b_q + BW'(1);
	assign lvl_count  = BW'(1) << (top_q - l_q);
	assign grant_full = GW'(b_q << lvl_q) * GW'(MIN_BLOCK);
	assign blk        = div_quo >> lvl_q;

	// memory write port
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = node_addr;
		mem_wdata = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = (clr_q == top_addr);
			end
			ST_ATAKE, ST_FMA, ST_FMB: mem_we = 1'b1;
			ST_ASPL, ST_FSET: begin
				mem_we    = 1'b1;
				mem_wdata = 1'b1;
			end
			default: mem_we = 1'b0;
		endcase
	end

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign div_start = req_fire && (req.kind == bba_pkg::KIND_FREE) && (size_lvl <= top_q);

	bba_node_mem #(.DEPTH(NODES), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (node_addr),
		.rdata (mem_rdata)
	);

	bba_div #(.DIVISOR(MIN_BLOCK), .WIDTH(bba_pkg::OFFS_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (req.block_offset),
		.done     (div_done),
		.quotient (div_quo)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			top_q        <= LW'(TOP_INIT);
			clr_q        <= '0;
			l_q          <= '0;
			b_q          <= '0;
			lvl_q        <= '0;
			res_grant_q  <= '0;
			res_status_q <= bba_pkg::ST_OK;
		end else if (cfg.valid) begin
			top_q   <= ({1'b0, cfg.top_level} > 5'(LEVELS - 1)) ? LW'(LEVELS - 1)
			                                                    : LW'(cfg.top_level);
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NODES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						lvl_q <= size_lvl;
						l_q   <= size_lvl;
						b_q   <= '0;
						if (size_lvl > top_q) begin
							res_status_q <= bba_pkg::ST_TOO_BIG;
							res_grant_q  <= '0;
							state_q      <= ST_DONE;
						end else if (req.kind == bba_pkg::KIND_ALLOC) begin
							state_q <= ST_ARD;
						end else begin
							state_q <= ST_FDIV;
						end
					end
				end
				ST_ARD: state_q <= ST_ACHK;
				ST_ACHK: begin
					if (mem_rdata) begin
						state_q <= ST_ATAKE;
					end else if (b_next == lvl_count) begin
						if (l_q == top_q) begin
							res_status_q <= bba_pkg::ST_NO_FREE;
							res_grant_q  <= '0;
							state_q      <= ST_DONE;
						end else begin
							l_q     <= l_q + LW'(1);
							b_q     <= '0;
							state_q <= ST_ARD;
						end
					end else begin
						b_q     <= b_next;
						state_q <= ST_ARD;
					end
				end
				ST_ATAKE, ST_ASPL: begin
					if (l_q == lvl_q) begin
						res_status_q <= bba_pkg::ST_OK;
						res_grant_q  <= grant_full[bba_pkg::OFFS_W-1:0];
						state_q      <= ST_DONE;
					end else begin
						l_q     <= l_q - LW'(1);
						b_q     <= b_q << 1;
						state_q <= ST_ASPL;
					end
				end
				ST_FDIV: begin
					if (div_done) begin
						res_grant_q <= '0;
						if ((blk >> (top_q - lvl_q)) != '0) begin
							res_status_q <= bba_pkg::ST_TOO_BIG;
							state_q      <= ST_DONE;
						end else begin
							res_status_q <= bba_pkg::ST_OK;
							b_q          <= BW'(blk);
							state_q      <= ST_FSET;
						end
					end
				end
				ST_FSET: state_q <= (l_q < top_q) ? ST_FRD : ST_DONE;
				ST_FRD:  state_q <= ST_FCHK;
				ST_FCHK: state_q <= mem_rdata ? ST_FMA : ST_DONE;
				ST_FMA:  state_q <= ST_FMB;
				ST_FMB: begin
					l_q     <= l_q + LW'(1);
					b_q     <= b_q >> 1;
					state_q <= ST_FSET;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_grant_q  <= res_grant_q;
			out_status_q <= res_status_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.grant_offset = out_grant_q;
	assign rsp.status       = out_status_q;

	// checks
	`BBA_ASSERT_NOW(a_no_write_idle, state_q == ST_IDLE, !mem_we)
	`BBA_ASSERT_NOW(a_scan_in_region, state_q == ST_ACHK, l_q <= top_q)
	`BBA_ASSERT_NEXT(a_done_loads, state_q == ST_DONE && !out_valid_q && !cfg.valid, out_valid_q)
	`BBA_ASSERT_NOW(a_merge_below_top, state_q == ST_FMA, l_q < top_q)

endmodule

@@ hdl/bba_node_mem.sv @@
// one-bit-per-node free map, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module bba_node_mem #(
	parameter int DEPTH = 1023,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	logic mem [DEPTH];
	logic rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/bba_div.sv @@
// constant divider by reciprocal multiplication, registered result, done the cycle after start
// no dependencies
`timescale 1ns / 1ps

module bba_div #(
	parameter int DIVISOR = 32,
	parameter int WIDTH   = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	output logic             done,
	output logic [WIDTH-1:0] quotient
);

	// exact for every WIDTH-bit dividend: shift = WIDTH + ceil(log2(DIVISOR))
	localparam int     SH    = WIDTH + $clog2(DIVISOR);
	localparam int     MW    = WIDTH + 2;
	localparam int     PW    = WIDTH + MW;
	localparam longint RECIP = ((longint'(1) << SH) + longint'(DIVISOR) - longint'(1))
	                           / longint'(DIVISOR);
	localparam logic [MW-1:0] RECIP_M = MW'(RECIP);

	logic [PW-1:0] prod_q;
	logic          done_q;

	// completion flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	// multiply by the scaled reciprocal
	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= PW'(dividend) * PW'(RECIP_M);
		end
	end

	assign done     = done_q;
	assign quotient = WIDTH'(prod_q >> SH);

endmodule

@@ dv/testbench.sv @@
// self-checking testbench for the buddy block allocator
// depends on bba_pkg, bba_ifs and buddy_block_allocator
`timescale 1ns / 1ps

module testbench;

	localparam int NODES      = (1 << bba_pkg::LEVELS_DEF) - 1;
	localparam int STALL_LIM  = 20000;
	localparam int HOLD_LEN   = 400;
	localparam int DRAIN_WAIT = 60;

	typedef struct packed {
		logic [bba_pkg::KIND_W-1:0]  kind;
		logic [bba_pkg::BYTES_W-1:0] nbytes;
		logic [bba_pkg::OFFS_W-1:0]  offs;
	} alloc_req_t;

	typedef struct packed {
		logic [bba_pkg::OFFS_W-1:0]   grant;
		logic [bba_pkg::STATUS_W-1:0] status;
	} alloc_rsp_t;

	typedef struct {
		bit          map [NODES];
		int unsigned top;
	} buddy_state_t;

	typedef struct {
		logic [bba_pkg::OFFS_W-1:0]  offs;
		logic [bba_pkg::BYTES_W-1:0] nbytes;
	} live_blk_t;

	logic clk;
	logic arst_n;

	bba_req_if req ();
	bba_rsp_if rsp ();
	bba_cfg_if cfg ();

	buddy_block_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source),
		.cfg    (cfg.sink)
	);

	alloc_req_t   pending_reqs [$];
	alloc_rsp_t   expected_grants [$];
	live_blk_t    live_blocks [$];
	buddy_state_t gen_state;
	buddy_state_t chk_state;
	int           send_idle_pct;
	int           recv_idle_pct;
	bit           hold_request;
	int           hold_left;
	int           quiet_cycles;
	int           errors;
	int           outstanding;

	// clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// node slot of a block in the free map
	function automatic int node_slot(int unsigned lvl, int unsigned blk);
		int idx;
		idx = ((1 << (bba_pkg::LEVELS_DEF - 1 - lvl)) - 1) + blk;
		return (idx < NODES) ? idx : NODES - 1;
	endfunction

	// smallest level whose block holds the size
	function automatic int unsigned level_of(logic [bba_pkg::BYTES_W-1:0] nbytes);
		for (int unsigned l = 0; l < bba_pkg::LEVELS_DEF; l++) begin
			if (nbytes <= (bba_pkg::MIN_BLOCK_DEF << l))
				return l;
		end
		return bba_pkg::LEVELS_DEF;
	endfunction

	// region reinit with only the top block free
	function automatic void region_init(ref buddy_state_t st,
			input logic [bba_pkg::TOP_W-1:0] top);
		st.top = (top > bba_pkg::LEVELS_DEF - 1) ? bba_pkg::LEVELS_DEF - 1 : top;
		foreach (st.map[i])
			st.map[i] = 1'b0;
		st.map[node_slot(st.top, 0)] = 1'b1;
	endfunction

	// allocator behavior for one request
	function automatic alloc_rsp_t buddy_apply(ref buddy_state_t st, input alloc_req_t r);
		alloc_rsp_t  res;
		int unsigned lvl;
		int unsigned l;
		int unsigned b;
		int unsigned blk;
		bit          found;
		lvl = level_of(r.nbytes);
		res.grant = '0;
		res.status = bba_pkg::ST_OK;
		found = 1'b0;
		b = 0;
		if (lvl > st.top) begin
			res.status = bba_pkg::ST_TOO_BIG;
		end else if (r.kind == bba_pkg::KIND_ALLOC) begin
			// lowest-addressed free block, smallest level first
			for (l = lvl; l <= st.top; l++) begin
				for (b = 0; b < (1 << (st.top - l)); b++) begin
					if (st.map[node_slot(l, b)]) begin
						found = 1'b1;
						break;
					end
				end
				if (found)
					break;
			end
			if (!found) begin
				res.status = bba_pkg::ST_NO_FREE;
			end else begin
				st.map[node_slot(l, b)] = 1'b0;
				// split down, upper halves go free
				while (l > lvl) begin
					l--;
					b = b << 1;
					st.map[node_slot(l, b + 1)] = 1'b1;
				end
				res.grant = bba_pkg::OFFS_W'(b * (bba_pkg::MIN_BLOCK_DEF << lvl));
			end
		end else begin
			blk = r.offs / (bba_pkg::MIN_BLOCK_DEF << lvl);
			if (blk >= (1 << (st.top - lvl))) begin
				res.status = bba_pkg::ST_TOO_BIG;
			end else begin
				l = lvl;
				b = blk;
				st.map[node_slot(l, b)] = 1'b1;
				// merge with free buddies upward
				while (l < st.top && st.map[node_slot(l, b ^ 1)]) begin
					st.map[node_slot(l, b)] = 1'b0;
					st.map[node_slot(l, b ^ 1)] = 1'b0;
					l++;
					b = b >> 1;
					st.map[node_slot(l, b)] = 1'b1;
				end
			end
		end
		return res;
	endfunction

	// queue one request and track live blocks for well-formed frees
	task automatic queue_request(input logic [bba_pkg::KIND_W-1:0] kind, input int nbytes,
			input int offs);
		alloc_req_t r;
		alloc_rsp_t res;
		r.kind = kind;
		r.nbytes = bba_pkg::BYTES_W'(nbytes);
		r.offs = bba_pkg::OFFS_W'(offs);
		res = buddy_apply(gen_state, r);
		if (kind == bba_pkg::KIND_ALLOC && res.status == bba_pkg::ST_OK)
			live_blocks.push_back('{res.grant, r.nbytes});
		outstanding++;
		pending_reqs.push_back(r);
	endtask

	// every queued request has its result back
	task automatic wait_drained();
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// register write while the block is idle
	task automatic write_top(input logic [bba_pkg::TOP_W-1:0] top);
		wait_drained();
		cfg.top_level <= top;
		cfg.valid <= 1'b1;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		region_init(gen_state, top);
		region_init(chk_state, top);
		live_blocks.delete();
	endtask

	// edge cases at the current region size
	task automatic queue_directed();
		int region;
		region = bba_pkg::MIN_BLOCK_DEF << gen_state.top;
		queue_request(bba_pkg::KIND_ALLOC, 0, 16383);
		queue_request(bba_pkg::KIND_ALLOC, 1, 0);
		queue_request(bba_pkg::KIND_ALLOC, 32, 0);
		queue_request(bba_pkg::KIND_ALLOC, 33, 0);
		queue_request(bba_pkg::KIND_ALLOC, region, 0);
		queue_request(bba_pkg::KIND_ALLOC, region + 1, 0);
		queue_request(bba_pkg::KIND_ALLOC, 16384, 0);
		queue_request(bba_pkg::KIND_FREE, region + 1, 0);
		queue_request(bba_pkg::KIND_FREE, 16384, 16383);
		// free beyond the region, or at its last offset for a full-size region
		queue_request(bba_pkg::KIND_FREE, 32, (region < 16384) ? region : 16383);
		// misaligned and repeated frees
		queue_request(bba_pkg::KIND_FREE, 32, 1);
		queue_request(bba_pkg::KIND_FREE, 32, 0);
		queue_request(bba_pkg::KIND_FREE, 32, 0);
		// whole region back, then fill it up to exhaustion
		queue_request(bba_pkg::KIND_FREE, region, 0);
		live_blocks.delete();
		queue_request(bba_pkg::KIND_ALLOC, region, 0);
		queue_request(bba_pkg::KIND_ALLOC, region, 0);
		queue_request(bba_pkg::KIND_ALLOC, 32, 0);
		queue_request(bba_pkg::KIND_FREE, region, 0);
		live_blocks.delete();
		queue_request(bba_pkg::KIND_ALLOC, 64, 0);
		queue_request(bba_pkg::KIND_ALLOC, 32, 0);
	endtask

	// random mix: mostly alloc/free pairs, some noise
	task automatic queue_random(input int count);
		int        pick;
		int        idx;
		int        lvl;
		live_blk_t blk;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 55 || (pick < 92 && live_blocks.size() == 0)) begin
				lvl = $urandom_range(0, gen_state.top);
				if ($urandom_range(3) == 0)
					lvl = $urandom_range(0, (gen_state.top > 2) ? 2 : gen_state.top);
				queue_request(bba_pkg::KIND_ALLOC,
					$urandom_range(1, bba_pkg::MIN_BLOCK_DEF << lvl),
					$urandom_range(16383));
			end else if (pick < 92) begin
				idx = $urandom_range(live_blocks.size() - 1);
				blk = live_blocks[idx];
				live_blocks.delete(idx);
				queue_request(bba_pkg::KIND_FREE, blk.nbytes, blk.offs);
			end else begin
				queue_request(($urandom_range(1) == 0) ? bba_pkg::KIND_ALLOC
					: bba_pkg::KIND_FREE, $urandom_range(16384), $urandom_range(16383));
			end
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.kind <= bba_pkg::KIND_ALLOC;
			req.req_bytes <= '0;
			req.block_offset <= '0;
		end else if (!req.valid || req.ready) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				alloc_req_t r;
				r = pending_reqs.pop_front();
				req.kind <= r.kind;
				req.req_bytes <= r.nbytes;
				req.block_offset <= r.offs;
				req.valid <= 1'b1;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// result ready with random stalls and a long hold-off each time hold_request is set
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			hold_left <= 0;
		end else if (hold_request && hold_left == 0) begin
			hold_left <= HOLD_LEN;
			rsp.ready <= 1'b0;
		end else if (hold_left > 1) begin
			hold_left <= hold_left - 1;
			rsp.ready <= 1'b0;
		end else begin
			hold_left <= 0;
			rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// predict accepted requests, check results
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				expected_grants.push_back(buddy_apply(chk_state,
					'{req.kind, req.req_bytes, req.block_offset}));
			if (rsp.valid && rsp.ready) begin
				if (expected_grants.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, actual grant %0d status %0d",
						$time, rsp.grant_offset, rsp.status);
				end else begin
					alloc_rsp_t want;
					want = expected_grants.pop_front();
					outstanding--;
					if (rsp.grant_offset !== want.grant) begin
						errors++;
						$display("%0t: grant_offset expected %0d actual %0d",
							$time, want.grant, rsp.grant_offset);
					end
					if (rsp.status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, rsp.status);
					end
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIM) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// phases over several region sizes and idle patterns
	initial begin
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.top_level = '0;
		send_idle_pct = 19;
		recv_idle_pct = 81;
		hold_request = 1'b0;
		quiet_cycles = 0;
		errors = 0;
		outstanding = 0;
		region_init(gen_state, bba_pkg::TOP_RESET);
		region_init(chk_state, bba_pkg::TOP_RESET);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		queue_directed();
		queue_random(100);
		write_top(4'd0);
		queue_directed();
		queue_random(40);
		// long receiver hold-off while requests keep coming
		hold_request <= 1'b1;
		@(posedge clk);
		hold_request <= 1'b0;
		write_top(4'd9);
		send_idle_pct = 81;
		recv_idle_pct = 19;
		queue_directed();
		queue_random(120);
		write_top(4'd15);
		queue_directed();
		queue_random(80);
		write_top(4'd2);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_directed();
		queue_random(80);
		write_top(4'd7);
		queue_directed();
		queue_random(80);
		// sender pauses until every result is back
		wait_drained();
		queue_random(80);
		hold_request <= 1'b1;
		@(posedge clk);
		hold_request <= 1'b0;
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
